### design/lsm_pkg.sv
// Package for the line substring matcher: result kinds, flag bits, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lsm_pkg;
    localparam logic [7:0] NEWLINE = 8'h0A;
    localparam logic       KIND_LINE = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;
    localparam int         FLAG_CASE = 0;
    localparam int         FLAG_INVERT = 1;
    localparam int         FLAG_COUNT = 2;
    localparam int         FLAG_LIST = 3;
    localparam logic [2:0] REG_LEN = 3'd0;
    localparam logic [2:0] REG_W0 = 3'd1;
    localparam logic [2:0] REG_W1 = 3'd2;
    localparam logic [2:0] REG_W2 = 3'd3;
    localparam logic [2:0] REG_W3 = 3'd4;
    localparam logic [2:0] REG_MODE = 3'd5;

    // classified event handed from front to back
    typedef struct packed {
        logic line_end;
        logic line_sel;
        logic eos;
    } t_event;

    function automatic logic [7:0] fold(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
        return r;
    endfunction
endpackage
`default_nettype wire

### design/lsm_front.sv
// Front: stores line bytes in a window, compares against the pattern, classifies
// each word into a line-end/summary event. Depends on lsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsm_front #(
    parameter int PATTERN_MAX = 32,
    parameter int LINE_MAX = 4095
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic                         i_has_byte,
    input  wire logic                         i_end_of_stream,
    input  wire logic                         i_take,
    input  wire logic [5:0]                   i_len,
    input  wire logic [255:0]                 i_pattern,
    input  wire logic [3:0]                   i_mode,
    output logic                              o_valid,
    output lsm_pkg::t_event                   o_event
);
    localparam int PW = $clog2(LINE_MAX + 1);
    localparam int EW = $clog2(PATTERN_MAX + 1);

    logic [7:0]      r_win [PATTERN_MAX];
    logic [PW-1:0]   r_pos;
    logic            r_hit;
    logic            r_list_done;
    logic [EW-1:0]   eff_len;
    logic            store, is_nl, eq, hit_now, sel, end_ln, end_eos;
    logic [7:0]      nb;

    always_comb begin
        if ({26'd0, i_len} > PATTERN_MAX) eff_len = EW'(PATTERN_MAX);
        else eff_len = EW'(i_len);
    end

    assign store = i_valid && i_has_byte && !r_list_done && (r_pos < PW'(LINE_MAX));
    assign is_nl = i_valid && i_has_byte && !r_list_done && (i_data_byte == lsm_pkg::NEWLINE);

    // window view with the incoming byte at position 0
    always_comb begin
        eq = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (i == 0) nb = i_data_byte;
            else nb = r_win[i-1];
            for (int j = 0; j < PATTERN_MAX; j++) begin
                if (EW'(j) < eff_len && EW'(i + j + 1) == eff_len) begin
                    if (lsm_pkg::fold(nb, i_mode[lsm_pkg::FLAG_CASE]) !=
                        lsm_pkg::fold((j < 32) ? i_pattern[8*(j%32) +: 8] : 8'h00,
                                      i_mode[lsm_pkg::FLAG_CASE]))
                        eq = 1'b0;
                end
            end
        end
        hit_now = store && ({{(32-PW){1'b0}}, r_pos} + 32'd1 >= {{(32-EW){1'b0}}, eff_len})
                  && eq;
    end

    assign end_ln  = is_nl || (i_valid && i_end_of_stream && !r_list_done &&
                     (r_pos != '0 || store));
    assign sel = ((r_hit || hit_now || eff_len == '0) != i_mode[lsm_pkg::FLAG_INVERT]);
    assign end_eos = i_valid && i_end_of_stream;

    assign o_valid = i_valid && (end_ln || end_eos);
    assign o_event = '{line_end: end_ln, line_sel: sel, eos: end_eos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_hit <= 1'b0;
            r_list_done <= 1'b0;
            for (int i = 0; i < PATTERN_MAX; i++) r_win[i] <= 8'h00;
        end else if (i_take) begin
            if (end_eos) begin
                r_pos <= '0;
                r_hit <= 1'b0;
                r_list_done <= 1'b0;
                for (int i = 0; i < PATTERN_MAX; i++) r_win[i] <= 8'h00;
            end else begin
                if (store) begin
                    r_win[0] <= i_data_byte;
                    for (int i = 1; i < PATTERN_MAX; i++) r_win[i] <= r_win[i-1];
                end
                if (end_ln) begin
                    r_pos <= '0;
                    r_hit <= 1'b0;
                    if (sel && i_mode[lsm_pkg::FLAG_LIST]) r_list_done <= 1'b1;
                end else begin
                    if (store) r_pos <= r_pos + PW'(1);
                    if (hit_now) r_hit <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

### design/lsm_queue.sv
// Two-entry event queue between front and back.
// Depends on lsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsm_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  lsm_pkg::t_event      i_event,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output lsm_pkg::t_event      o_event
);
    lsm_pkg::t_event r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_event = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_event;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

### design/lsm_back.sv
// Back: counts lines and selections, emits line reports and the summary.
// Depends on lsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsm_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  lsm_pkg::t_event      i_event,
    input  wire logic [3:0]      i_mode,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic                 o_kind,
    output logic [31:0]          o_line_number,
    output logic [31:0]          o_sel_count,
    output logic                 o_any_match,
    output logic                 o_last
);
    logic [31:0] r_lines, r_sel;
    logic        r_line_done;    // line part of current event already reported
    logic        r_valid, r_kind, r_last;
    logic [31:0] r_num, r_cnt;
    logic        free, go, do_line, rep;
    logic [31:0] n_lines, n_sel, sel_after;

    assign free = !r_valid || !i_stall;
    assign go = i_valid && free;
    assign n_lines = (r_lines == '1) ? r_lines : r_lines + 32'd1;
    assign n_sel   = (r_sel == '1) ? r_sel : r_sel + 32'd1;
    assign do_line = i_event.line_end && !r_line_done;
    assign rep = do_line && i_event.line_sel &&
                 (i_mode[lsm_pkg::FLAG_LIST] || !i_mode[lsm_pkg::FLAG_COUNT]);
    assign sel_after = (do_line && i_event.line_sel) ? n_sel : r_sel;

    // hold an event whose report shares the word with the stream end; summary follows
    assign o_pop = go && !(rep && i_event.eos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines <= '0;
            r_sel <= '0;
            r_line_done <= 1'b0;
            r_valid <= 1'b0;
        end else if (go) begin
            r_valid <= rep || i_event.eos;
            if (rep) begin
                r_kind <= lsm_pkg::KIND_LINE;
                r_num <= n_lines;
                r_last <= !i_event.eos;
            end else begin
                r_kind <= lsm_pkg::KIND_SUMMARY;
                r_num <= '0;
                r_last <= 1'b1;
            end
            r_cnt <= sel_after;
            if (i_event.eos && !rep) begin
                r_lines <= '0;
                r_sel <= '0;
            end else begin
                r_lines <= do_line ? n_lines : r_lines;
                r_sel <= sel_after;
            end
            r_line_done <= rep && i_event.eos;
        end else if (free) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_line_number = r_num;
    assign o_sel_count = r_cnt;
    assign o_any_match = r_cnt != '0;
    assign o_last = r_last;
endmodule
`default_nettype wire

### design/line_substring_matcher_core.sv
// Fixed-string line search: one byte word per cycle, back-to-back, unless input is stalled.
// Front classifies in the accept cycle; a two-entry queue feeds the back, which
// registers results: a line report passes through the queue, then the back's output register.
// A stream end that also closes a reported line gives two results, the line report
// and then the summary; input stalls only while both queue entries are taken.
// Synchronous active-low reset clears counters, window, queue; config registers reset to 0.
`timescale 1ns / 1ps
`default_nettype none
module line_substring_matcher_core #(
    parameter int PATTERN_MAX = 32,
    parameter int LINE_MAX = 4095
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_stream,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic [31:0]      o_line_number,
    output logic [31:0]      o_sel_count,
    output logic             o_any_match,
    output logic             o_last
);
    logic [5:0]   r_len;
    logic [255:0] r_pat;
    logic [3:0]   r_mode;
    logic         f_valid, q_full, q_empty, pop, take;
    lsm_pkg::t_event f_event, q_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_pat <= '0;
            r_mode <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lsm_pkg::REG_LEN:  r_len <= i_cfg_data[5:0];
                lsm_pkg::REG_W0:   r_pat[63:0] <= i_cfg_data;
                lsm_pkg::REG_W1:   r_pat[127:64] <= i_cfg_data;
                lsm_pkg::REG_W2:   r_pat[191:128] <= i_cfg_data;
                lsm_pkg::REG_W3:   r_pat[255:192] <= i_cfg_data;
                lsm_pkg::REG_MODE: r_mode <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_stall = q_full;
    assign take = i_valid && !q_full;

    lsm_front #(.PATTERN_MAX(PATTERN_MAX), .LINE_MAX(LINE_MAX)) u_front (
        .i_clk, .i_rst_n, .i_valid, .i_data_byte, .i_has_byte, .i_end_of_stream,
        .i_take(take), .i_len(r_len), .i_pattern(r_pat), .i_mode(r_mode),
        .o_valid(f_valid), .o_event(f_event)
    );

    lsm_queue u_queue (
        .i_clk, .i_rst_n, .i_push(take && f_valid), .i_event(f_event),
        .i_pop(pop), .o_full(q_full), .o_empty(q_empty), .o_event(q_event)
    );

    lsm_back u_back (
        .i_clk, .i_rst_n, .i_valid(!q_empty), .i_event(q_event), .i_mode(r_mode),
        .o_pop(pop), .o_valid, .i_stall, .o_kind, .o_line_number, .o_sel_count,
        .o_any_match, .o_last
    );
endmodule
`default_nettype wire

### design/lsm_checker.sv
// Port-level checks for line_substring_matcher_core, bound to the top level.
// Depends only on the core, into which it is bound.
`timescale 1ns / 1ps
`default_nettype none
module lsm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_kind,
    input wire logic [31:0] o_line_number,
    input wire logic [31:0] o_sel_count,
    input wire logic        o_any_match,
    input wire logic        o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_line_number))
        else $error("stalled word changed");
    a_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_any_match == (o_sel_count != 32'd0)))
        else $error("any_match mismatch");
    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_last && o_line_number == 32'd0)
        else $error("bad summary");
    a_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_line_number != 32'd0 && o_sel_count != 32'd0)
        else $error("bad line report");
endmodule
bind line_substring_matcher_core lsm_checker u_lsm_checker (.*);
`default_nettype wire

### tb/line_substring_matcher_core_tb.sv
// Self-checking bench for line_substring_matcher_core: a byte-stream predictor
// computes every line report and summary, and the bench compares them in order.
// Depends on lsm_pkg and the core.
`timescale 1ns / 1ps
module line_substring_matcher_core_tb;

    typedef struct packed {
        logic        kind;
        logic [31:0] line_number;
        logic [31:0] sel_count;
        logic        any_match;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eos;
        logic       chk;
        t_result    res;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 0;
    logic        i_has_byte = 0;
    logic        i_end_of_stream = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = 0;
    logic [63:0] i_cfg_data = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic        o_kind;
    logic [31:0] o_line_number;
    logic [31:0] o_sel_count;
    logic        o_any_match;
    logic        o_last;

    line_substring_matcher_core dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor copy of the registers and stream state
    logic [5:0]  pat_len;
    logic [63:0] pat_word [4];
    logic [3:0]  mode;
    logic [7:0]  window [32];
    int unsigned line_pos;
    logic        line_hit;
    logic [31:0] line_cnt;
    logic [31:0] sel_cnt;
    logic        list_done;

    t_result     pending_results [$];
    int          errors = 0;
    logic        quiet = 0;
    logic        hold_long = 0;

    task automatic report(input string what, input t_result got, input t_result exp);
        errors++;
        $display("%0t mismatch %s: got %h exp %h", $realtime, what, got, exp);
    endtask

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        if (mode[lsm_pkg::FLAG_CASE] && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
        return b;
    endfunction

    function automatic logic [7:0] pat_byte(input int i);
        if (i >= 32) return 8'h00;
        return pat_word[i / 8][8 * (i % 8) +: 8];
    endfunction

    function automatic int eff_len();
        return pat_len > 32 ? 32 : pat_len;
    endfunction

    task automatic clear_stream();
        for (int i = 0; i < 32; i++) window[i] = 0;
        line_pos = 0;
        line_hit = 0;
        line_cnt = 0;
        sel_cnt = 0;
        list_done = 0;
    endtask

    function automatic t_result make_result(input logic kind, input logic [31:0] num);
        t_result r;
        r.kind = kind;
        r.line_number = num;
        r.sel_count = sel_cnt;
        r.any_match = sel_cnt != 0;
        r.last = 0;
        return r;
    endfunction

    task automatic store_byte(input logic [7:0] b);
        int  len;
        bit  eq;
        eq = 1;
        if (line_pos >= 4095) return;
        for (int i = 31; i > 0; i--) window[i] = window[i - 1];
        window[0] = b;
        line_pos++;
        len = eff_len();
        if (line_pos < len) return;
        for (int i = 0; i < len; i++)
            if (fold_byte(window[len - 1 - i]) != fold_byte(pat_byte(i))) eq = 0;
        if (eq) line_hit = 1;
    endtask

    task automatic close_line(ref t_result outs [$]);
        bit hit;
        bit sel;
        hit = line_hit || eff_len() == 0;
        sel = hit != mode[lsm_pkg::FLAG_INVERT];
        if (line_cnt != 32'hFFFF_FFFF) line_cnt++;
        if (sel) begin
            if (sel_cnt != 32'hFFFF_FFFF) sel_cnt++;
            if (mode[lsm_pkg::FLAG_LIST]) begin
                outs.push_back(make_result(lsm_pkg::KIND_LINE, line_cnt));
                list_done = 1;
            end else if (!mode[lsm_pkg::FLAG_COUNT]) begin
                outs.push_back(make_result(lsm_pkg::KIND_LINE, line_cnt));
            end
        end
        line_pos = 0;
        line_hit = 0;
    endtask

    task automatic predict_word(input logic [7:0] b, input logic has, input logic eos,
                                output t_result outs [$]);
        outs = {};
        if (has && !list_done) begin
            store_byte(b);
            if (b == lsm_pkg::NEWLINE) close_line(outs);
        end
        if (eos) begin
            if (!list_done && line_pos > 0) close_line(outs);
            outs.push_back(make_result(lsm_pkg::KIND_SUMMARY, 0));
            clear_stream();
        end
        if (outs.size() > 0) outs[outs.size() - 1].last = 1;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_valid     <= 0;
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 0;
        case (idx)
            lsm_pkg::REG_LEN:  pat_len = val[5:0];
            lsm_pkg::REG_W0:   pat_word[0] = val;
            lsm_pkg::REG_W1:   pat_word[1] = val;
            lsm_pkg::REG_W2:   pat_word[2] = val;
            lsm_pkg::REG_W3:   pat_word[3] = val;
            lsm_pkg::REG_MODE: mode = val[3:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // send one word; chk carries a typed-in expectation for directed rows
    task automatic send_word(input logic [7:0] b, input logic has, input logic eos,
                             input logic chk, input t_result typed);
        t_result outs [$];
        t_result first;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid         <= 1;
        i_data_byte     <= b;
        i_has_byte      <= has;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_word(b, has, eos, outs);
        first = '0;
        if (outs.size() > 0) first = outs[0];
        if (chk && (outs.size() != 1 || first != typed))
            report("directed", first, typed);
        foreach (outs[k]) pending_results.push_back(outs[k]);
    endtask

    // receive side: random stall bursts, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_stall <= 1;
                n = 0;
                while (n < 200) begin
                    @(posedge i_clk);
                    n++;
                end
                i_stall <= 0;
                hold_long = 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_stall <= 1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_stall <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_kind, o_line_number, o_sel_count, o_any_match, o_last};
            if (pending_results.size() == 0) begin
                report("unexpected", got, '0);
            end else begin
                if (got != pending_results[0]) report("result", got, pending_results[0]);
                void'(pending_results.pop_front());
            end
        end
    end

    t_row rows [9] = '{
        // after reset: empty pattern matches; bare end of empty stream
        '{8'h00, 1'b0, 1'b1, 1'b1, '{lsm_pkg::KIND_SUMMARY, 32'd0, 32'd0, 1'b0, 1'b1}},
        '{8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{lsm_pkg::NEWLINE, 1'b1, 1'b0, 1'b1, '{lsm_pkg::KIND_LINE, 32'd1, 32'd1, 1'b1, 1'b1}},
        '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, 1'b0, '0},
        '{8'h41, 1'b1, 1'b0, 1'b0, '0},
        '{lsm_pkg::NEWLINE, 1'b1, 1'b1, 1'b0, '0},
        '{8'h61, 1'b1, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b1, 1'b0, '0}
    };

    task automatic random_text(input int count, input bit alpha);
        logic [7:0] b;
        int         r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12) b = lsm_pkg::NEWLINE;
            else if (alpha) b = 8'h41 + 8'($urandom_range(0, 2)) +
                                ($urandom_range(0, 1) ? 8'h20 : 8'h00);
            else b = 8'($urandom);
            send_word(b, r < 95 || r >= 98, r >= 97, 0, '0);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        pat_len = 0;
        mode = 0;
        for (int i = 0; i < 4; i++) pat_word[i] = 0;
        clear_stream();
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].data, rows[i].has, rows[i].eos, rows[i].chk,
                                    rows[i].res);
        wait_idle();

        // pattern "Ab" case folded, then inverted, count and list modes
        write_reg(lsm_pkg::REG_W0, 64'h6241);
        write_reg(lsm_pkg::REG_LEN, 6'd2);
        for (int m = 0; m < 16; m++) begin
            write_reg(lsm_pkg::REG_MODE, 4'(m));
            random_text(25, 1);
            send_word(8'h00, 0, 1, 0, '0);
            wait_idle();
        end

        // 32-byte and oversize patterns; stray index write
        write_reg(lsm_pkg::REG_MODE, 0);
        for (int i = 0; i < 4; i++)
            write_reg(3'(lsm_pkg::REG_W0 + i), 64'h4141_4141_4141_4141);
        write_reg(lsm_pkg::REG_LEN, 6'd32);
        write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 40; i++) send_word(8'h41, 1, 0, 0, '0);
        send_word(lsm_pkg::NEWLINE, 1, 1, 0, '0);
        wait_idle();
        write_reg(lsm_pkg::REG_LEN, 6'd63);
        write_reg(lsm_pkg::REG_W3, 64'hFFFF_FFFF_FFFF_FFFF);
        random_text(30, 0);
        send_word(8'h00, 0, 1, 0, '0);
        wait_idle();

        // block fills while the receiver holds off
        write_reg(lsm_pkg::REG_LEN, 0);
        write_reg(lsm_pkg::REG_MODE, 0);
        hold_long = 1;
        for (int i = 0; i < 20; i++) send_word(lsm_pkg::NEWLINE, 1, 0, 0, '0);
        wait_idle();

        // random phases with random configuration
        for (int p = 0; p < 8; p++) begin
            write_reg(lsm_pkg::REG_W0, {$urandom, $urandom});
            write_reg(lsm_pkg::REG_W1, {$urandom, $urandom});
            write_reg(lsm_pkg::REG_LEN, 6'($urandom_range(0, 3)));
            write_reg(lsm_pkg::REG_MODE, 4'($urandom));
            if (p == 7) quiet = 1;
            random_text(75, p % 2);
            send_word(8'h00, 0, 1, 0, '0);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("line_substring_matcher_core_tb: clean");
        end else begin
            $display("line_substring_matcher_core_tb: errors");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("line_substring_matcher_core_tb: errors");
        $finish;
    end
endmodule

### files.f
design/lsm_pkg.sv
design/lsm_front.sv
design/lsm_queue.sv
design/lsm_back.sv
design/line_substring_matcher_core.sv
design/lsm_checker.sv
tb/line_substring_matcher_core_tb.sv
